/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl of the prefix correlator
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked property, switched off while reset is asserted
`define CPAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property that also holds during reset
`define CPAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPAC_ASSERT(label, clk, rst_n, prop, msg)
`define CPAC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/cpac_pkg.sv */
// types, constants and register indexes of the prefix correlator
// no dependencies; imported by the top level of the block and by the testbench
`default_nettype none
package cpac_pkg;

    // parameter defaults
    localparam int SYMBOL_LENGTH_DEF = 4096;
    localparam int MAX_WINDOW_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;

    // window lengths
    localparam int NORMAL_PREFIX = 144 * 2;
    localparam int PREFIX_STEP   = 16;
    localparam int LEN_FULL_W    = 14;

    // arithmetic widths
    localparam int TERM_W = 33;
    localparam int RING_W = 3 * TERM_W;
    localparam int SUM_W  = 44;
    localparam int EN_W   = 43;
    localparam int MET_W  = 112;
    localparam int MET_QB = 24;
    localparam int PH_W   = 68;
    localparam int PH_QB  = 23;
    localparam int FRAC_BITS = 16;
    localparam int MUL_STEPS = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMEROLOGY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;

    // output limits
    localparam logic [23:0] METRIC_MAX = 24'hFFFFFF;
    localparam logic [23:0] PHASE_MAX  = 24'h7FFFFF;
    localparam logic [23:0] PHASE_MIN  = 24'h800000;

    typedef struct packed {
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic        [23:0] metric;
        logic signed [23:0] phase_ratio;
        logic        [31:0] sample_index;
        logic               warming_up;
        logic               zero_divisor;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DV_GO,
        ST_DV_WAIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/cpac_ram.sv */
// generic single-clock ram, one write port, one read port, registered read
// no dependencies; used for the delay line and the term ring
`default_nettype none
module cpac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cpac_sqr.sv */
// shift-add squarer, one multiplier bit per cycle
// depends on nothing but its parameter; used for |P|^2 and R^2
`default_nettype none
module cpac_sqr #(
    parameter int W = 44
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    output      logic           busy,
    output      logic [2*W-1:0] p
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     mult_reg,  mult_next;
    logic [2*W-1:0]   mcand_reg, mcand_next;
    logic [2*W-1:0]   p_reg,     p_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             busy_reg,  busy_next;

    // one partial product per cycle
    always_comb
    begin
        mult_next  = mult_reg;
        mcand_next = mcand_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            mult_next  = a;
            mcand_next = (2*W)'(a);
            p_next     = '0;
            cnt_next   = CNT_W'(W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mult_reg[0])
            begin
                p_next = p_reg + mcand_reg;
            end
            mult_next  = mult_reg >> 1;
            mcand_next = mcand_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg  <= mult_next;
        mcand_reg <= mcand_next;
        p_reg     <= p_next;
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule
`default_nettype wire

/* hw/rtl/cpac_div.sv */
// restoring divider, one quotient bit per cycle, with overflow detect
// depends on nothing but its parameters; used for metric and phase ratio
`default_nettype none
module cpac_div #(
    parameter int W  = 68,
    parameter int QB = 23
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [W-1:0]  num,
    input  wire logic [W-1:0]  den,
    output      logic          busy,
    output      logic          sat,
    output      logic [QB-1:0] q
);

    localparam int CNT_W = $clog2(QB);

    logic [W-1:0]     rem_reg,  rem_next;
    logic [W-1:0]     dsh_reg,  dsh_next;
    logic [QB-1:0]    q_reg,    q_next;
    logic             sat_reg,  sat_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    // quotient overflows when num >= den * 2^QB, a zero divisor included
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = den << (QB - 1);
            q_next    = '0;
            sat_next  = (num >= (den << QB));
            cnt_next  = CNT_W'(QB - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QB-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign busy = busy_reg;
    assign sat  = sat_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

/* hw/rtl/cp_autocorrelation_with_phase.sv */
// top level of the cyclic prefix correlator with phase ratio
// depends on cpac_pkg, cpac_ram, cpac_sqr, cpac_div and assert_macros.svh
//
// A sample that is dropped by decimation, or a kept sample that has no partner one
// symbol earlier yet, is done once it is accepted. A kept sample with a partner
// goes through these steps in order: the accept cycle; the pair terms, one product
// at a time on the one shared 16x16 multiplier; one read-modify-write of the sums
// and the term ring; once the window is full, a start of the shift-add squarers and
// a wait on them, then a start of the restoring dividers and a wait on them; and the
// load of the output register, which waits while the previous result is still
// stalled in the output register. Both memories are read once, in the cycle a kept
// item is accepted; the delay line is written in that cycle at the entry it reads,
// which returns its old contents, and the ring is written back once. No clearing
// pass follows reset. A finished item waits in the output register while the next
// sample is taken.
`default_nettype none
`include "assert_macros.svh"
module cp_autocorrelation_with_phase #(
    parameter int SYMBOL_LENGTH = cpac_pkg::SYMBOL_LENGTH_DEF,
    parameter int MAX_WINDOW    = cpac_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS   = cpac_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output      logic                               sample_stall,
    input  wire cpac_pkg::in_item_t                 sample_item,
    output      logic                               result_valid,
    input  wire logic                               result_stall,
    output      cpac_pkg::out_item_t                result_item,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cpac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpac_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import cpac_pkg::*;

    localparam int DP_W  = $clog2(SYMBOL_LENGTH);
    localparam int KC_W  = $clog2(SYMBOL_LENGTH + 1);
    localparam int RP_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    // configuration
    logic [3:0] ratio_cfg_reg;
    logic [2:0] numerology_reg;
    logic       window_sel_reg;

    // control state
    state_t              state_reg,   state_next;
    logic [2:0]          phase_reg,   phase_next;
    logic [KC_W-1:0]     kc_reg,      kc_next;
    logic [DP_W-1:0]     dp_reg,      dp_next;
    logic [RP_W-1:0]     rp_reg,      rp_next;
    logic [LEN_W-1:0]    ps_reg,      ps_next;
    logic [31:0]         ri_reg,      ri_next;
    logic                warm_reg,    warm_next;
    logic [2:0]          step_reg,    step_next;
    logic                out_vld_reg, out_vld_next;
    logic signed [SUM_W-1:0] sum_cr_reg, sum_cr_next;
    logic signed [SUM_W-1:0] sum_ci_reg, sum_ci_next;
    logic [EN_W-1:0]         sum_en_reg, sum_en_next;

    // payload
    logic signed [15:0]       re_reg, re_next;
    logic signed [15:0]       im_reg, im_next;
    logic signed [TERM_W-1:0] cr_reg, cr_next;
    logic signed [TERM_W-1:0] ci_reg, ci_next;
    logic signed [TERM_W-1:0] en_reg, en_next;
    out_item_t                out_reg, out_next;

    // memory ports
    logic             dl_we, mem_re, ring_we;
    logic [31:0]      dl_rdata;
    logic [RING_W-1:0] ring_rdata;
    logic [RP_W-1:0]  ring_raddr;

    // arithmetic units
    logic             sq_start, dv_start;
    logic             sq_busy_r, sq_busy_i, sq_busy_e, dv_busy_m, dv_busy_p;
    logic [2*SUM_W-1:0] sq_p_r, sq_p_i, sq_p_e;
    logic             met_sat, ph_sat;
    logic [MET_QB-1:0] met_q;
    logic [PH_QB-1:0]  ph_q;

    // decoded input and effective stream state
    logic             accept, fs, keep, primed;
    logic [3:0]       ratio;
    logic [2:0]       ph_eff;
    logic [KC_W-1:0]  kc_eff;
    logic [DP_W-1:0]  dp_eff;
    logic [RP_W-1:0]  rp_eff;
    logic [LEN_W-1:0] ps_eff;
    logic [31:0]      ri_eff;
    logic [LEN_FULL_W-1:0] len_full;
    logic [LEN_W-1:0] len, k_full;
    logic signed [15:0] new_re, new_im, old_re, old_im;
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;
    logic signed [TERM_W-1:0] old_cr, old_ci, old_en;
    logic [SUM_W-1:0] pr_mag, pi_mag;
    logic             neg;
    logic [23:0]      phase_val;

    assign accept = sample_valid && !sample_stall;
    assign fs     = sample_item.frame_start;
    assign sample_stall = (state_reg != ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_cfg_reg  <= 4'd1;
            numerology_reg <= '0;
            window_sel_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DECIMATION: ratio_cfg_reg  <= cfg_data[3:0];
                CFG_NUMEROLOGY: numerology_reg <= cfg_data[2:0];
                CFG_WINDOW:     window_sel_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // clamped ratio and window length
    always_comb
    begin
        ratio = ratio_cfg_reg;
        if (ratio_cfg_reg == 4'd0)
        begin
            ratio = 4'd1;
        end
        else if (ratio_cfg_reg > 4'd8)
        begin
            ratio = 4'd8;
        end
        if (window_sel_reg)
        begin
            len_full = LEN_FULL_W'(NORMAL_PREFIX);
        end
        else
        begin
            len_full = LEN_FULL_W'(NORMAL_PREFIX)
                     + (LEN_FULL_W'(PREFIX_STEP) << ({1'b0, numerology_reg} + 4'd1));
        end
        if (len_full > LEN_FULL_W'(MAX_WINDOW))
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = len_full[LEN_W-1:0];
        end
    end

    // stream state as seen by this item, a frame start clearing it first
    assign ph_eff = fs ? '0 : phase_reg;
    assign kc_eff = fs ? '0 : kc_reg;
    assign dp_eff = fs ? '0 : dp_reg;
    assign rp_eff = fs ? '0 : rp_reg;
    assign ps_eff = fs ? '0 : ps_reg;
    assign ri_eff = fs ? '0 : ri_reg;
    assign keep   = (ph_eff == '0);
    assign primed = (kc_eff == KC_W'(SYMBOL_LENGTH));

    // ring slot written one window length ago
    assign k_full = LEN_W'(rp_eff)
                  + ((LEN_W'(rp_eff) >= len) ? LEN_W'(0) : LEN_W'(MAX_WINDOW)) - len;
    assign ring_raddr = k_full[RP_W-1:0];

    assign new_re = 16'(signed'(sample_item.sample_re[SAMPLE_BITS-1:0]));
    assign new_im = 16'(signed'(sample_item.sample_im[SAMPLE_BITS-1:0]));
    assign old_re = signed'(dl_rdata[15:0]);
    assign old_im = signed'(dl_rdata[31:16]);
    assign old_cr = signed'(ring_rdata[RING_W-1 -: TERM_W]);
    assign old_ci = signed'(ring_rdata[2*TERM_W-1 -: TERM_W]);
    assign old_en = signed'(ring_rdata[TERM_W-1:0]);

    // shared multiplier operands
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = old_re; mul_b = re_reg; end
            3'd1:    begin mul_a = old_im; mul_b = im_reg; end
            3'd2:    begin mul_a = old_im; mul_b = re_reg; end
            3'd3:    begin mul_a = old_re; mul_b = im_reg; end
            3'd4:    begin mul_a = old_re; mul_b = old_re; end
            default: begin mul_a = old_im; mul_b = old_im; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // magnitudes of the correlation sums
    assign pr_mag = sum_cr_reg[SUM_W-1] ? SUM_W'(-sum_cr_reg) : SUM_W'(sum_cr_reg);
    assign pi_mag = sum_ci_reg[SUM_W-1] ? SUM_W'(-sum_ci_reg) : SUM_W'(sum_ci_reg);
    assign neg    = sum_cr_reg[SUM_W-1] != sum_ci_reg[SUM_W-1];

    always_comb
    begin
        if (neg)
        begin
            phase_val = ph_sat ? PHASE_MIN : 24'(-signed'({1'b0, ph_q}));
        end
        else
        begin
            phase_val = ph_sat ? PHASE_MAX : {1'b0, ph_q};
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        kc_next      = kc_reg;
        dp_next      = dp_reg;
        rp_next      = rp_reg;
        ps_next      = ps_reg;
        ri_next      = ri_reg;
        warm_next    = warm_reg;
        step_next    = step_reg;
        sum_cr_next  = sum_cr_reg;
        sum_ci_next  = sum_ci_reg;
        sum_en_next  = sum_en_reg;
        re_next      = re_reg;
        im_next      = im_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        en_next      = en_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        dl_we        = 1'b0;
        mem_re       = 1'b0;
        ring_we      = 1'b0;
        sq_start     = 1'b0;
        dv_start     = 1'b0;
        if (out_vld_reg && !result_stall)
        begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    phase_next = (({1'b0, ph_eff} + 4'd1) >= ratio) ? '0 : ph_eff + 3'd1;
                    kc_next = kc_eff;
                    dp_next = dp_eff;
                    rp_next = rp_eff;
                    ps_next = ps_eff;
                    ri_next = ri_eff;
                    if (fs)
                    begin
                        sum_cr_next = '0;
                        sum_ci_next = '0;
                        sum_en_next = '0;
                    end
                    if (keep)
                    begin
                        dl_we   = 1'b1;
                        mem_re  = 1'b1;
                        re_next = new_re;
                        im_next = new_im;
                        dp_next = (dp_eff == DP_W'(SYMBOL_LENGTH - 1)) ? '0 : dp_eff + 1'b1;
                        if (!primed)
                        begin
                            kc_next = kc_eff + 1'b1;
                        end
                        warm_next = (ps_eff < len);
                        step_next = '0;
                        if (primed)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                case (step_reg)
                    3'd0:    cr_next = TERM_W'(prod);
                    3'd1:    cr_next = cr_reg + TERM_W'(prod);
                    3'd2:    ci_next = TERM_W'(prod);
                    3'd3:    ci_next = ci_reg - TERM_W'(prod);
                    3'd4:    en_next = TERM_W'(prod);
                    default: en_next = en_reg + TERM_W'(prod);
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(MUL_STEPS - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ring_we = 1'b1;
                if (warm_reg)
                begin
                    sum_cr_next = sum_cr_reg + SUM_W'(cr_reg);
                    sum_ci_next = sum_ci_reg + SUM_W'(ci_reg);
                    sum_en_next = sum_en_reg + EN_W'(en_reg);
                    state_next  = ST_DONE;
                end
                else
                begin
                    sum_cr_next = sum_cr_reg - SUM_W'(old_cr) + SUM_W'(cr_reg);
                    sum_ci_next = sum_ci_reg - SUM_W'(old_ci) + SUM_W'(ci_reg);
                    sum_en_next = sum_en_reg - EN_W'(old_en) + EN_W'(en_reg);
                    state_next  = ST_SQ_GO;
                end
                rp_next = (rp_reg == RP_W'(MAX_WINDOW - 1)) ? '0 : rp_reg + 1'b1;
                if (ps_reg != LEN_W'(MAX_WINDOW))
                begin
                    ps_next = ps_reg + 1'b1;
                end
            end
            ST_SQ_GO:
            begin
                sq_start   = 1'b1;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (!sq_busy_r && !sq_busy_i && !sq_busy_e)
                begin
                    state_next = ST_DV_GO;
                end
            end
            ST_DV_GO:
            begin
                dv_start   = 1'b1;
                state_next = ST_DV_WAIT;
            end
            ST_DV_WAIT:
            begin
                if (!dv_busy_m && !dv_busy_p)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || !result_stall)
                begin
                    out_vld_next          = 1'b1;
                    out_next.sample_index = ri_reg;
                    out_next.warming_up   = warm_reg;
                    if (warm_reg)
                    begin
                        out_next.metric       = '0;
                        out_next.phase_ratio  = '0;
                        out_next.zero_divisor = 1'b0;
                    end
                    else
                    begin
                        out_next.metric       = met_sat ? METRIC_MAX : met_q;
                        out_next.phase_ratio  = signed'(phase_val);
                        out_next.zero_divisor = (sum_en_reg == '0) || (sum_cr_reg == '0);
                    end
                    ri_next    = ri_reg + 32'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            kc_reg      <= '0;
            dp_reg      <= '0;
            rp_reg      <= '0;
            ps_reg      <= '0;
            ri_reg      <= '0;
            warm_reg    <= 1'b0;
            step_reg    <= '0;
            out_vld_reg <= 1'b0;
            sum_cr_reg  <= '0;
            sum_ci_reg  <= '0;
            sum_en_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            kc_reg      <= kc_next;
            dp_reg      <= dp_next;
            rp_reg      <= rp_next;
            ps_reg      <= ps_next;
            ri_reg      <= ri_next;
            warm_reg    <= warm_next;
            step_reg    <= step_next;
            out_vld_reg <= out_vld_next;
            sum_cr_reg  <= sum_cr_next;
            sum_ci_reg  <= sum_ci_next;
            sum_en_reg  <= sum_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg  <= re_next;
        im_reg  <= im_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        en_reg  <= en_next;
        out_reg <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result_item  = out_reg;

    // delay line, one symbol of kept samples
    cpac_ram #(
        .WIDTH (32),
        .DEPTH (SYMBOL_LENGTH)
    ) u_delay (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dp_eff),
        .wdata ({new_im, new_re}),
        .re    (mem_re),
        .raddr (dp_eff),
        .rdata (dl_rdata)
    );

    // ring of per-pair terms over the window
    cpac_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (rp_reg),
        .wdata ({cr_reg, ci_reg, en_reg}),
        .re    (mem_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // squares of the sums
    cpac_sqr #(.W(SUM_W)) u_sq_r (
        .clk (clk), .rst_n (rst_n), .start (sq_start),
        .a (pr_mag), .busy (sq_busy_r), .p (sq_p_r)
    );
    cpac_sqr #(.W(SUM_W)) u_sq_i (
        .clk (clk), .rst_n (rst_n), .start (sq_start),
        .a (pi_mag), .busy (sq_busy_i), .p (sq_p_i)
    );
    cpac_sqr #(.W(SUM_W)) u_sq_e (
        .clk (clk), .rst_n (rst_n), .start (sq_start),
        .a (SUM_W'(sum_en_reg)), .busy (sq_busy_e), .p (sq_p_e)
    );

    // metric |P|^2 * 2^16 / R^2
    cpac_div #(.W(MET_W), .QB(MET_QB)) u_div_met (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (MET_W'({(2*SUM_W+1)'(sq_p_r) + (2*SUM_W+1)'(sq_p_i),
                        FRAC_BITS'(0)})),
        .den   (MET_W'(sq_p_e)),
        .busy  (dv_busy_m),
        .sat   (met_sat),
        .q     (met_q)
    );

    // phase ratio |Im P| * 2^16 / |Re P|
    cpac_div #(.W(PH_W), .QB(PH_QB)) u_div_ph (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (PH_W'({pi_mag, FRAC_BITS'(0)})),
        .den   (PH_W'(pr_mag)),
        .busy  (dv_busy_p),
        .sat   (ph_sat),
        .q     (ph_q)
    );

    // checks
    `CPAC_ASSERT(a_out_from_done, clk, rst_n, $rose(result_valid) |-> $past(state_reg == ST_DONE), "result raised outside done state")
    `CPAC_ASSERT(a_warm_zero, clk, rst_n, (result_valid && result_item.warming_up) |-> (result_item.metric == '0 && result_item.phase_ratio == '0 && !result_item.zero_divisor), "warming result not zero")
    `CPAC_ASSERT(a_frame_clears, clk, rst_n, (accept && sample_item.frame_start) |=> (sum_en_reg == '0 && sum_cr_reg == '0 && ps_reg == '0), "frame start did not clear sums")
    `CPAC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !result_valid, "result valid during reset")

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench of cp_autocorrelation_with_phase: long captures with shaped content
// depends on cpac_pkg and the rtl of the block; holds its own model of the correlator
`timescale 1ns / 100ps

module tb_top;

    import cpac_pkg::*;

    // keeps the expected results of the correlator in step with the accepted samples
    class corr_scoreboard;
        int unsigned ratio_reg;
        int unsigned numer_reg;
        int unsigned wsel_reg;
        logic [31:0] delay_mem [4096];
        longint      re_terms [1024];
        longint      im_terms [1024];
        longint      en_terms [1024];
        logic [43:0] sum_re;
        logic [43:0] sum_im;
        logic [42:0] sum_en;
        int unsigned dec_phase;
        int unsigned kept_cnt;
        int unsigned delay_ptr;
        int unsigned term_ptr;
        int unsigned pairs_cnt;
        logic [31:0] out_idx;
        out_item_t   expected_q [$];
        int          errors;

        function new();
            ratio_reg = 1;
            numer_reg = 0;
            wsel_reg  = 0;
            errors    = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            sum_re    = '0;
            sum_im    = '0;
            sum_en    = '0;
            dec_phase = 0;
            kept_cnt  = 0;
            delay_ptr = 0;
            term_ptr  = 0;
            pairs_cnt = 0;
            out_idx   = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DECIMATION: ratio_reg = val;
                CFG_NUMEROLOGY: numer_reg = val[2:0];
                CFG_WINDOW:     wsel_reg  = val[0];
                default: ;
            endcase
        endfunction

        static function int unsigned window_len(int unsigned numer, int unsigned wsel);
            int unsigned len;
            len = wsel ? NORMAL_PREFIX : NORMAL_PREFIX + (PREFIX_STEP << (1 + numer));
            return (len > 1024) ? 1024 : len;
        endfunction

        function int unsigned eff_ratio();
            if (ratio_reg == 0)
                return 1;
            return (ratio_reg > 8) ? 8 : ratio_reg;
        endfunction

        // one accepted sample: update the model and queue any result it causes
        function void note(in_item_t it);
            int unsigned r;
            int unsigned len;
            int unsigned k;
            bit          keep;
            bit          primed;
            bit          warm;
            logic [31:0] old;
            longint      ar, ai, br, bi, cr, ci, en, pr, pi, q;
            logic [127:0] apr, api, num, den;
            out_item_t   exp;
            r = eff_ratio();
            if (it.frame_start)
                clear_stream();
            keep = (dec_phase == 0);
            dec_phase = (dec_phase + 1 >= r) ? 0 : dec_phase + 1;
            if (!keep)
                return;
            primed = kept_cnt >= 4096;
            old = delay_mem[delay_ptr];
            delay_mem[delay_ptr] = {it.sample_im, it.sample_re};
            delay_ptr = (delay_ptr + 1) % 4096;
            if (kept_cnt != 32'hFFFF_FFFF)
                kept_cnt++;
            if (!primed)
                return;

            // pair terms of the earlier and the current sample
            ar = longint'($signed(old[15:0]));
            ai = longint'($signed(old[31:16]));
            br = longint'(it.sample_re);
            bi = longint'(it.sample_im);
            cr = ar * br + ai * bi;
            ci = ai * br - ar * bi;
            en = ar * ar + ai * ai;

            // sliding window sums
            len  = window_len(numer_reg, wsel_reg);
            warm = pairs_cnt < len;
            if (!warm)
            begin
                k = (term_ptr + 1024 - len) % 1024;
                sum_re -= re_terms[k][43:0];
                sum_im -= im_terms[k][43:0];
                sum_en -= en_terms[k][42:0];
            end
            re_terms[term_ptr] = cr;
            im_terms[term_ptr] = ci;
            en_terms[term_ptr] = en;
            sum_re += cr[43:0];
            sum_im += ci[43:0];
            sum_en += en[42:0];
            term_ptr = (term_ptr + 1) % 1024;
            if (pairs_cnt < 1024)
                pairs_cnt++;

            exp = '0;
            exp.sample_index = out_idx;
            exp.warming_up   = warm;
            if (!warm)
            begin
                pr  = longint'($signed(sum_re));
                pi  = longint'($signed(sum_im));
                apr = 128'((pr < 0) ? -pr : pr);
                api = 128'((pi < 0) ? -pi : pi);
                // metric, saturating
                if (sum_en == 0)
                    exp.metric = METRIC_MAX;
                else
                begin
                    num = (apr * apr + api * api) << FRAC_BITS;
                    den = 128'(sum_en) * 128'(sum_en);
                    if (num >= (den << 24))
                        exp.metric = METRIC_MAX;
                    else
                        exp.metric = 24'(num / den);
                end
                // phase ratio, saturating, truncated toward zero
                if (pr == 0)
                    exp.phase_ratio = (pi < 0) ? PHASE_MIN : PHASE_MAX;
                else
                begin
                    q = longint'((api << FRAC_BITS) / apr);
                    if ((pr < 0) != (pi < 0))
                        exp.phase_ratio = (q >= (64'sd1 <<< 23)) ? PHASE_MIN : 24'(-q);
                    else
                        exp.phase_ratio = (q >= (64'sd1 <<< 23)) ? PHASE_MAX : 24'(q);
                end
                exp.zero_divisor = (sum_en == 0) || (pr == 0);
            end
            expected_q.push_back(exp);
            out_idx++;
        endfunction

        // one accepted result against the oldest expectation
        function void check(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result metric=%h phase=%h index=%0d warm=%b zdiv=%b",
                         $time, got.metric, got.phase_ratio, got.sample_index,
                         got.warming_up, got.zero_divisor);
                return;
            end
            exp = expected_q.pop_front();
            if (got !== exp)
            begin
                errors++;
                $display("%0t: mismatch expected metric=%h phase=%h index=%0d warm=%b zdiv=%b",
                         $time, exp.metric, exp.phase_ratio, exp.sample_index,
                         exp.warming_up, exp.zero_divisor);
                $display("%0t:          actual   metric=%h phase=%h index=%0d warm=%b zdiv=%b",
                         $time, got.metric, got.phase_ratio, got.sample_index,
                         got.warming_up, got.zero_divisor);
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    // content shapes of a capture
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_ZERO_ROT_POS,
        SHAPE_GAIN,
        SHAPE_ROT_NEG
    } shape_t;

    logic                        clk;
    logic                        rst_n;
    logic                        sample_valid;
    logic                        sample_stall;
    in_item_t                    sample_item;
    logic                        result_valid;
    logic                        result_stall;
    out_item_t                   result_item;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    corr_scoreboard              sb;
    int                          send_idle;
    int                          recv_idle;
    int                          quiet_cycles;
    logic signed [15:0]          early_re [4096];
    logic signed [15:0]          early_im [4096];

    cp_autocorrelation_with_phase u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check(result_item);
        result_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("cp_autocorrelation_with_phase test failed");
                $finish;
            end
        end
    end

    // offer one item, with random idle cycles before it
    task automatic put(in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= it;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note(it);
    endtask

    // wait until every expected result has come, then let the block settle
    task automatic drain(int settle);
        sample_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic configure(int unsigned ratio, int unsigned numer, int unsigned wsel);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DECIMATION;
        cfg_data  <= CFG_DATA_W'(ratio);
        @(posedge clk);
        sb.set_reg(CFG_DECIMATION, CFG_DATA_W'(ratio));
        cfg_index <= CFG_NUMEROLOGY;
        cfg_data  <= CFG_DATA_W'(numer);
        @(posedge clk);
        sb.set_reg(CFG_NUMEROLOGY, CFG_DATA_W'(numer));
        cfg_index <= CFG_WINDOW;
        cfg_data  <= CFG_DATA_W'(wsel);
        @(posedge clk);
        sb.set_reg(CFG_WINDOW, CFG_DATA_W'(wsel));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_part(int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    // one capture: a full symbol of earlier samples, then paired samples of a given shape
    task automatic run_capture(shape_t shape, int extra, bit hold_off);
        in_item_t    it;
        int unsigned r;
        int unsigned len;
        int          p;
        int          kk;
        int          j;
        r   = sb.eff_ratio();
        len = sb.window_len(sb.numer_reg, sb.wsel_reg);
        for (kk = 0; kk < 4096 + int'(len) + extra; kk++)
        begin
            it.frame_start = (kk == 0);
            if (kk < 4096)
            begin
                // earlier symbol
                it.sample_re = rand_part(32767);
                it.sample_im = rand_part(32767);
                if (shape == SHAPE_GAIN)
                begin
                    it.sample_re = rand_part(127);
                    it.sample_im = rand_part(127);
                end
                else if (shape == SHAPE_ZERO_ROT_POS && kk < 340)
                begin
                    it.sample_re = '0;
                    it.sample_im = '0;
                end
                else if (shape == SHAPE_RANDOM && kk < 4)
                begin
                    it.sample_re = kk[0] ? 16'sh8000 : 16'sh7FFF;
                    it.sample_im = kk[1] ? 16'sh8000 : 16'sh7FFF;
                end
                early_re[kk] = it.sample_re;
                early_im[kk] = it.sample_im;
            end
            else
            begin
                // later symbol, shaped from its partner
                p = kk - 4096;
                case (shape)
                    SHAPE_ZERO_ROT_POS:
                    begin
                        it.sample_re = -early_im[p];
                        it.sample_im = early_re[p];
                    end
                    SHAPE_ROT_NEG:
                    begin
                        it.sample_re = early_im[p];
                        it.sample_im = -early_re[p];
                    end
                    SHAPE_GAIN:
                    begin
                        it.sample_re = early_re[p] <<< 8;
                        it.sample_im = early_im[p] <<< 8;
                    end
                    default:
                    begin
                        it.sample_re = 16'($urandom);
                        it.sample_im = 16'($urandom);
                    end
                endcase
                if (hold_off && p == int'(len) + 10)
                    drain(0);
            end
            put(it);
            // samples dropped by decimation
            for (j = 1; j < int'(r); j++)
            begin
                it.frame_start = 1'b0;
                it.sample_re   = 16'($urandom);
                it.sample_im   = 16'($urandom);
                put(it);
            end
        end
    endtask

    task automatic set_mode(int phase);
        case (phase % 3)
            0:
            begin
                send_idle = 21;
                recv_idle = 84;
            end
            1:
            begin
                send_idle = 84;
                recv_idle = 21;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    initial
    begin
        in_item_t it;
        int       n;
        sb           = new();
        quiet_cycles = 0;
        send_idle    = 0;
        recv_idle    = 0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_item  = '0;
        result_stall = 1'b1;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_DECIMATION;
        cfg_data     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extremes first, pause for the pipeline once
        set_mode(0);
        run_capture(SHAPE_RANDOM, 40, 1'b1);
        drain(100);

        // large window, content scaled up one symbol later
        set_mode(1);
        configure(3, 4, 0);
        run_capture(SHAPE_GAIN, 40, 1'b0);
        drain(100);

        // normal window, silent start then quarter-turn rotation
        set_mode(2);
        configure(8, 0, 1);
        run_capture(SHAPE_ZERO_ROT_POS, 60, 1'b0);
        drain(100);

        // zero ratio, clamped window, opposite rotation
        set_mode(3);
        configure(0, 7, 0);
        run_capture(SHAPE_ROT_NEG, 40, 1'b0);
        drain(100);

        // noise with stray capture restarts
        set_mode(4);
        configure(2, 1, 1);
        for (n = 0; n < 400; n++)
        begin
            it.sample_re   = 16'($urandom);
            it.sample_im   = 16'($urandom);
            it.frame_start = ($urandom_range(49) == 0);
            put(it);
        end
        drain(100);

        // ratio above range
        set_mode(5);
        configure(15, 2, 0);
        run_capture(SHAPE_RANDOM, 40, 1'b0);
        drain(100);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("cp_autocorrelation_with_phase test passed");
        else
            $display("cp_autocorrelation_with_phase test failed");
        $finish;
    end

endmodule
